// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define EHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define EHC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

// ----- rtl/ehc_pkg.sv -----
// ----------------------------------------------------------------------------
// ehc_pkg
// shared types and constants of the holiday check unit
// ----------------------------------------------------------------------------
`default_nettype none

package ehc_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned KEY_W   = MONTH_W + DAY_W;

  localparam logic [YEAR_W-1:0] MIN_YEAR = 12'd1583;

  // computus sequence, one step per cycle
  typedef enum logic [3:0] {
    STP_CENT,
    STP_Q19,
    STP_A,
    STP_Q7,
    STP_C,
    STP_MM,
    STP_S,
    STP_MN,
    STP_DX,
    STP_DQ,
    STP_DD,
    STP_E,
    STP_EASTER,
    STP_TABLE
  } step_t;

  typedef struct packed {
    logic  load;
    logic  calc_en;
    step_t step;
    logic  look_en;
    logic  send;
  } cmd_t;

  typedef struct packed {
    logic year_low;
    logic year_hit;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/ehc_dpath.sv -----
// ----------------------------------------------------------------------------
// ehc_dpath
// date registers, computus arithmetic, holiday table and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ehc_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [ehc_pkg::DAY_W-1:0]       in_day,
  input  wire logic [ehc_pkg::MONTH_W-1:0]     in_month,
  input  wire logic [ehc_pkg::YEAR_W-1:0]      in_year,
  input  wire ehc_pkg::cmd_t                   cmd,
  output ehc_pkg::status_t                     sts,
  output logic                                 holiday
);

  localparam int unsigned NUM_FIXED  = 5;
  localparam int unsigned NUM_EASTER = 4;

  // fixed holidays as {month, day}
  localparam logic [ehc_pkg::KEY_W-1:0] FIXED_KEY [NUM_FIXED] = '{
    {4'd1,  5'd1},
    {4'd5,  5'd1},
    {4'd10, 5'd3},
    {4'd12, 5'd25},
    {4'd12, 5'd26}
  };

  // easter offsets biased by +2 so they stay unsigned
  localparam logic [6:0] OFS_BIASED [NUM_EASTER] = '{7'd0, 7'd3, 7'd41, 7'd52};

  // x mod 7 for x below 256, reciprocal 586/4096
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [17:0] p;
    logic [5:0]  q;
    logic [7:0]  r;
    p = 18'(x) * 18'd586;
    q = p[17:12];
    r = x - 8'(q * 8'd7);
    return r[2:0];
  endfunction

  // day count from march 1st to {month, day}; easter offsets stay within mar..jun
  function automatic logic [ehc_pkg::KEY_W-1:0] from_march(input logic [6:0] n);
    logic [ehc_pkg::KEY_W-1:0] k;
    if (n < 7'd31) begin
      k = {4'd3, 5'(n + 7'd1)};
    end else if (n < 7'd61) begin
      k = {4'd4, 5'(n - 7'd30)};
    end else if (n < 7'd92) begin
      k = {4'd5, 5'(n - 7'd60)};
    end else begin
      k = {4'd6, 5'(n - 7'd91)};
    end
    return k;
  endfunction

  function automatic logic [1:0] b_bits(input logic [ehc_pkg::YEAR_W-1:0] y);
    return y[1:0];
  endfunction

  logic [ehc_pkg::DAY_W-1:0]   day_r;
  logic [ehc_pkg::MONTH_W-1:0] month_r;
  logic [ehc_pkg::YEAR_W-1:0]  year_r;
  logic [ehc_pkg::YEAR_W-1:0]  cached_year_r;
  logic [5:0]                  cent_r;
  logic [9:0]                  q_r;
  logic [4:0]                  a_r;
  logic [2:0]                  c_r;
  logic [3:0]                  mm_r;
  logic [5:0]                  s_r;
  logic [4:0]                  bigm_r;
  logic [2:0]                  bign_r;
  logic [8:0]                  x_r;
  logic [4:0]                  dd_r;
  logic [2:0]                  e_r;
  logic [5:0]                  easter_n_r;
  logic [ehc_pkg::KEY_W-1:0]   ent_r [NUM_EASTER];
  logic                        hit_r;
  logic                        holiday_r;

  logic [24:0] p_cent;
  logic [23:0] p_q19;
  logic [25:0] p_q7;
  logic [11:0] a_full;
  logic [11:0] c_full;
  logic [8:0]  mm_v;
  logic [16:0] p_mm;
  logic [5:0]  mn_t;
  logic [20:0] p_dq;
  logic [8:0]  d_full;
  logic [4:0]  d_v;
  logic [7:0]  e_sum;
  logic [ehc_pkg::KEY_W-1:0] key;
  logic        match;

  always_comb begin
    p_cent = 25'(year_r) * 25'd5243;
    p_q19  = 24'(year_r) * 24'd3450;
    p_q7   = 26'(year_r) * 26'd9363;
    a_full = year_r - 12'({2'b00, q_r} * 12'd19);
    c_full = year_r - 12'({2'b00, q_r} * 12'd7);
    mm_v   = {cent_r, 3'b000} + 9'd13;
    p_mm   = 17'(mm_v) * 17'd164;
    mn_t   = 6'd15 + s_r - 6'(mm_r);
    p_dq   = 21'(x_r) * 21'd2185;
    d_full = x_r - 9'(9'(q_r[4:0]) * 9'd30);
    d_v    = d_full[4:0];
    e_sum  = 8'({b_bits(year_r), 1'b0}) + 8'({c_r, 2'b00}) + 8'(dd_r) * 8'd6 + 8'(bign_r);
  end

  always_comb begin
    key   = {month_r, day_r};
    match = 1'b0;
    for (int i = 0; i < NUM_FIXED; i++) begin
      if (FIXED_KEY[i] == key) begin
        match = 1'b1;
      end
    end
    for (int i = 0; i < NUM_EASTER; i++) begin
      if (ent_r[i] == key) begin
        match = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cached_year_r <= '0;
      easter_n_r    <= '0;
      for (int i = 0; i < NUM_EASTER; i++) begin
        ent_r[i] <= '0;
      end
    end else if (cmd.calc_en) begin
      case (cmd.step)
        ehc_pkg::STP_EASTER: begin
          // march 22nd plus dd plus e, counted from march 1st
          easter_n_r    <= 6'd21 + 6'(dd_r) + 6'(e_r);
          cached_year_r <= year_r;
        end
        ehc_pkg::STP_TABLE: begin
          for (int i = 0; i < NUM_EASTER; i++) begin
            ent_r[i] <= from_march(7'(easter_n_r) + OFS_BIASED[i] - 7'd2);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r   <= in_day;
      month_r <= in_month;
      year_r  <= in_year;
      hit_r   <= 1'b0;
    end else if (cmd.look_en) begin
      hit_r <= match;
    end
    if (cmd.send) begin
      holiday_r <= hit_r;
    end
    if (cmd.calc_en) begin
      case (cmd.step)
        ehc_pkg::STP_CENT: cent_r <= p_cent[24:19];
        ehc_pkg::STP_Q19:  q_r    <= {2'b00, p_q19[23:16]};
        ehc_pkg::STP_A:    a_r    <= a_full[4:0];
        ehc_pkg::STP_Q7:   q_r    <= p_q7[25:16];
        ehc_pkg::STP_C:    c_r    <= c_full[2:0];
        ehc_pkg::STP_MM:   mm_r   <= 4'(p_mm[16:12] - 5'd2);
        // year / 400 equals cent / 4
        ehc_pkg::STP_S:    s_r    <= cent_r - {2'b00, cent_r[5:2]} - 6'd2;
        ehc_pkg::STP_MN: begin
          bigm_r <= (mn_t >= 6'd30) ? 5'(mn_t - 6'd30) : mn_t[4:0];
          bign_r <= mod7(8'(s_r) + 8'd6);
        end
        ehc_pkg::STP_DX:   x_r    <= 9'(bigm_r) + 9'(a_r) * 9'd19;
        ehc_pkg::STP_DQ:   q_r    <= {5'b00000, p_dq[20:16]};
        ehc_pkg::STP_DD: begin
          // the two exception cases of the computus
          if (d_v == 5'd29) begin
            dd_r <= 5'd28;
          end else if (d_v == 5'd28 && a_r >= 5'd11) begin
            dd_r <= 5'd27;
          end else begin
            dd_r <= d_v;
          end
        end
        ehc_pkg::STP_E:    e_r    <= mod7(e_sum);
        default: begin
        end
      endcase
    end
  end

  assign sts.year_low = (year_r < ehc_pkg::MIN_YEAR);
  assign sts.year_hit = (year_r == cached_year_r);
  assign holiday      = holiday_r;

endmodule

`default_nettype wire

// ----- rtl/ehc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ehc_ctrl
// sequencer for accept, computus steps, table lookup and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module ehc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire ehc_pkg::status_t  sts,
  output ehc_pkg::cmd_t          cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CALC,
    ST_LOOK,
    ST_SEND
  } state_t;

  state_t          state_r, state_nxt;
  ehc_pkg::step_t  step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    cmd.load    = (state_r == ST_IDLE) && in_tvalid;
    cmd.calc_en = (state_r == ST_CALC);
    cmd.step    = step_r;
    cmd.look_en = (state_r == ST_LOOK);
    cmd.send    = (state_r == ST_SEND) && slot_free;
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = cmd.send ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.year_low) begin
          state_nxt = ST_SEND;
        end else if (sts.year_hit) begin
          state_nxt = ST_LOOK;
        end else begin
          state_nxt = ST_CALC;
          step_nxt  = ehc_pkg::STP_CENT;
        end
      end
      ST_CALC: begin
        if (step_r == ehc_pkg::STP_TABLE) begin
          state_nxt = ST_LOOK;
        end else begin
          step_nxt = ehc_pkg::step_t'(step_r + 4'd1);
        end
      end
      ST_LOOK: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= ehc_pkg::STP_CENT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/easter_holiday_check_unit.sv -----
// ----------------------------------------------------------------------------
// easter_holiday_check_unit
// reports whether a gregorian date is one of nine fixed or easter-based holidays
// ----------------------------------------------------------------------------
// channel | dir | fields (tdata lsb first)              | beat
// in_     | in  | day[4:0] month[8:5] year[20:9], pad 0  | one date
// out_    | out | holiday[0], pad 0                      | one flag per date
//
// a new year goes from accept to result through check, 14 computus and
// table steps at one per cycle, lookup and send
// a cached year: check, lookup, send; a year below 1583: check, send
// the block returns to idle after each send before the next date can be accepted
// synchronous active-low reset clears the sequencer and the cached year
// the next date is taken while the previous result beat waits in its register
// ----------------------------------------------------------------------------
`default_nettype none

module easter_holiday_check_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // day[4:0], month[8:5], year[20:9]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // holiday[0]
);

  ehc_pkg::cmd_t    cmd;
  ehc_pkg::status_t sts;
  logic             holiday;

  ehc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ehc_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_day   (in_tdata[4:0]),
    .in_month (in_tdata[8:5]),
    .in_year  (in_tdata[20:9]),
    .cmd      (cmd),
    .sts      (sts),
    .holiday  (holiday)
  );

  assign out_tdata = {7'b0000000, holiday};

endmodule

`default_nettype wire

// ----- rtl/ehc_checker.sv -----
// ----------------------------------------------------------------------------
// ehc_checker
// port-level checks of the holiday check unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ehc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata
);

  logic in_beat;

  assign in_beat   = in_tvalid && in_tready;

  // a stalled result beat holds
  `EHC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed under stall")

  // every date needs at least check and send before the next one
  `EHC_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_beat, !in_tready ##1 !in_tready, "input taken too early")

  // a result only appears while the block is busy with a date
  `EHC_ASSERT_IMP(a_out_from_busy, clk, rst_n, $rose(out_tvalid), $past(!in_tready), "result without work")

  // only the flag bit can be set
  `EHC_ASSERT_IMP(a_out_pad, clk, rst_n, out_tvalid, out_tdata[7:1] == 7'b0000000, "pad bits set")

endmodule

bind easter_holiday_check_unit ehc_checker u_chk (.*);

`default_nettype wire
